// ===== rtl/core/pcfd_pkg.sv =====
package pcfd_pkg;

    // Sizes of the configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Default pin count and the widest pin field of a frame
    localparam int PIN_COUNT_DEF = 64;
    localparam int PIN_BYTE_W    = 8;

    // Decoupling queue between parser and executor
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIGITAL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MASK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED_MASK     = 2'd2;

    // Write kinds
    localparam logic [1:0] KIND_DIGITAL = 2'd0;
    localparam logic [1:0] KIND_PWM     = 2'd1;
    localparam logic [1:0] KIND_LED     = 2'd2;

    // Frame completion status
    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_EARLY_END  = 2'd1;
    localparam logic [1:0] ST_BAD_HEADER = 2'd2;

    // Frame constants
    localparam logic [7:0] HEADER_BYTE = 8'hAA;
    localparam logic [7:0] PCT_FULL    = 8'd100;
    localparam logic [7:0] DUTY_MAX    = 8'd255;

    // Percent to duty: floor(p * 255 / 100) == (p * PWM_RECIP) >> PWM_SHIFT for p <= 100
    localparam int          PWM_SHIFT = 19;
    localparam logic [20:0] PWM_RECIP = 21'd1336965;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_first;
        logic       frame_last;
    } in_item_t;

    typedef struct packed {
        logic       write_valid;
        logic [1:0] write_kind;
        logic [5:0] pin_number;
        logic [7:0] level_or_duty;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_done;
        logic [1:0] frame_status;
    } out_item_t;

    // Classified command from parser to executor
    typedef struct packed {
        logic                  has_entry;
        logic [1:0]            kind;
        logic [PIN_BYTE_W-1:0] pin;
        logic [7:0]            value;
        logic [7:0]            red;
        logic [7:0]            green;
        logic                  done;
        logic [1:0]            status;
    } cmd_t;

endpackage

// ===== rtl/core/pcfd_front.sv =====
module pcfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  pcfd_pkg::in_item_t in_item,
    output logic              cmd_push,
    output pcfd_pkg::cmd_t    cmd
);
    import pcfd_pkg::*;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_DCOUNT = 8'b0000_0010,
        PH_DENTRY = 8'b0000_0100,
        PH_PCOUNT = 8'b0000_1000,
        PH_PENTRY = 8'b0001_0000,
        PH_LCOUNT = 8'b0010_0000,
        PH_LENTRY = 8'b0100_0000,
        PH_BAD    = 8'b1000_0000
    } phase_t;

    phase_t     phase_reg, phase_next, phase_cur;
    logic [7:0] left_reg, left_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] pin_reg, pin_next;
    logic [7:0] red_reg, red_next;
    logic [7:0] green_reg, green_next;
    logic [7:0] b;

    // Parse one byte and classify it
    always_comb
    begin
        b          = in_item.data_byte;
        phase_cur  = in_item.frame_first ? PH_HEADER : phase_reg;
        phase_next = phase_cur;
        left_next  = left_reg;
        idx_next   = idx_reg;
        pin_next   = pin_reg;
        red_next   = red_reg;
        green_next = green_reg;

        cmd.has_entry = 1'b0;
        cmd.kind      = KIND_DIGITAL;
        cmd.pin       = pin_reg;
        cmd.value     = b;
        cmd.red       = red_reg;
        cmd.green     = green_reg;
        cmd.done      = 1'b0;
        cmd.status    = ST_COMPLETE;

        case (phase_cur)
            PH_HEADER:
            begin
                phase_next = (b == HEADER_BYTE) ? PH_DCOUNT : PH_BAD;
            end
            PH_DCOUNT:
            begin
                left_next  = b;
                idx_next   = 2'd0;
                phase_next = (b != 8'd0) ? PH_DENTRY : PH_PCOUNT;
            end
            PH_PCOUNT:
            begin
                left_next  = b;
                idx_next   = 2'd0;
                phase_next = (b != 8'd0) ? PH_PENTRY : PH_LCOUNT;
            end
            PH_DENTRY, PH_PENTRY:
            begin
                if (idx_reg == 2'd0)
                begin
                    pin_next = b;
                    idx_next = 2'd1;
                end
                else
                begin
                    cmd.has_entry = 1'b1;
                    cmd.kind      = (phase_cur == PH_DENTRY) ? KIND_DIGITAL : KIND_PWM;
                    idx_next      = 2'd0;
                    left_next     = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = (phase_cur == PH_DENTRY) ? PH_PCOUNT : PH_LCOUNT;
                    end
                end
            end
            PH_LCOUNT:
            begin
                left_next  = b;
                idx_next   = 2'd0;
                phase_next = PH_LENTRY;
            end
            PH_LENTRY:
            begin
                if (left_reg != 8'd0)
                begin
                    case (idx_reg)
                        2'd0:
                        begin
                            pin_next = b;
                            idx_next = 2'd1;
                        end
                        2'd1:
                        begin
                            red_next = b;
                            idx_next = 2'd2;
                        end
                        2'd2:
                        begin
                            green_next = b;
                            idx_next   = 2'd3;
                        end
                        default:
                        begin
                            cmd.has_entry = 1'b1;
                            cmd.kind      = KIND_LED;
                            idx_next      = 2'd0;
                            left_next     = left_reg - 8'd1;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase

        // Close the frame and report
        if (in_item.frame_last)
        begin
            cmd.done = 1'b1;
            if (phase_next == PH_BAD)
                cmd.status = ST_BAD_HEADER;
            else if (phase_next == PH_LENTRY)
                cmd.status = ST_COMPLETE;
            else
                cmd.status = ST_EARLY_END;
            phase_next = PH_HEADER;
            left_next  = 8'd0;
            idx_next   = 2'd0;
        end
    end

    assign cmd_push = in_fire && (cmd.has_entry || cmd.done);

    // Advance parse control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            left_reg  <= 8'd0;
            idx_reg   <= 2'd0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold entry bytes
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pin_reg   <= pin_next;
            red_reg   <= red_next;
            green_reg <= green_next;
        end
    end

endmodule

// ===== rtl/core/pcfd_queue.sv =====
module pcfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pcfd_pkg::cmd_t push_data,
    input  logic           pop,
    output pcfd_pkg::cmd_t head,
    output logic           not_empty,
    output logic           full
);
    import pcfd_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers with wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/pcfd_back.sv =====
module pcfd_back #(
    parameter int PIN_COUNT = pcfd_pkg::PIN_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PIN_COUNT-1:0] digital_mask,
    input  logic [PIN_COUNT-1:0] pwm_mask,
    input  logic [PIN_COUNT-1:0] led_mask,
    input  logic                 head_valid,
    input  pcfd_pkg::cmd_t       head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pcfd_pkg::out_item_t  out_data
);
    import pcfd_pkg::*;

    localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam int PAD_W = 1 << PIN_W;

    logic [PIN_COUNT-1:0] mask_sel;
    logic [PAD_W-1:0]     mask_pad;
    logic                 pin_ok;
    logic                 has_out;
    logic [27:0]          duty_prod;
    logic [7:0]           duty;
    out_item_t            result;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg;

    // Select the mask for this kind and test the pin
    always_comb
    begin
        case (head.kind)
            KIND_DIGITAL: mask_sel = digital_mask;
            KIND_PWM:     mask_sel = pwm_mask;
            KIND_LED:     mask_sel = led_mask;
            default:      mask_sel = '0;
        endcase
        mask_pad = PAD_W'(mask_sel);
        pin_ok   = (head.pin < PIN_BYTE_W'(PIN_COUNT)) && mask_pad[head.pin[PIN_W-1:0]];
    end

    // Scale percent to duty, saturate above full scale
    assign duty_prod = 28'(head.value[6:0]) * 28'(PWM_RECIP);
    assign duty      = (head.value > PCT_FULL) ? DUTY_MAX : duty_prod[PWM_SHIFT+7:PWM_SHIFT];

    // Build the result item
    always_comb
    begin
        result              = '0;
        result.frame_done   = head.done;
        result.frame_status = head.done ? head.status : ST_COMPLETE;
        if (head.has_entry && pin_ok)
        begin
            result.write_valid = 1'b1;
            result.write_kind  = head.kind;
            result.pin_number  = head.pin[5:0];
            case (head.kind)
                KIND_DIGITAL:
                    result.level_or_duty = {7'd0, (head.value != 8'd0)};
                KIND_PWM:
                    result.level_or_duty = duty;
                default:
                begin
                    result.red   = head.red;
                    result.green = head.green;
                    result.blue  = head.value;
                end
            endcase
        end
        has_out = result.write_valid || result.frame_done;
    end

    // Drain the queue whenever the output register is free
    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || out_ready)
            out_valid_next = head_valid && has_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Hold result until transfer
    always_ff @(posedge clk)
    begin
        if (pop && has_out)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/pin_command_frame_decoder_unit.sv =====
// A result passes the command queue and then the output register before it is presented.
// Throughput: one byte per cycle while the command queue is not full; the parser, a
// two-entry command queue and the output register each take one item per cycle.
// Bytes with no entry and no frame report skip the queue; unmasked entries drop at its head.
// Reset (rst_n low, asynchronous): masks clear to zero, parser expects a header, queue and
// output register empty.
module pin_command_frame_decoder_unit #(
    parameter int PIN_COUNT = pcfd_pkg::PIN_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [pcfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcfd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pcfd_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pcfd_pkg::out_item_t                 out_data
);
    import pcfd_pkg::*;

    logic [PIN_COUNT-1:0] digital_mask_reg;
    logic [PIN_COUNT-1:0] pwm_mask_reg;
    logic [PIN_COUNT-1:0] led_mask_reg;
    logic                 in_fire;
    logic                 cmd_push;
    cmd_t                 cmd;
    cmd_t                 head;
    logic                 head_valid;
    logic                 q_full;
    logic                 pop;

    // Write configuration masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digital_mask_reg <= '0;
            pwm_mask_reg     <= '0;
            led_mask_reg     <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_DIGITAL_MASK: digital_mask_reg <= cfg_data[PIN_COUNT-1:0];
                REG_PWM_MASK:     pwm_mask_reg     <= cfg_data[PIN_COUNT-1:0];
                REG_LED_MASK:     led_mask_reg     <= cfg_data[PIN_COUNT-1:0];
                default:          ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    pcfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_item  (in_data),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    pcfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid),
        .full      (q_full)
    );

    pcfd_back #(
        .PIN_COUNT (PIN_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .digital_mask (digital_mask_reg),
        .pwm_mask     (pwm_mask_reg),
        .led_mask     (led_mask_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

`ifndef SYNTH
    // Every presented result carries a write or a frame report
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.write_valid || out_data.frame_done))
        else $error("empty result presented");

    // Digital writes carry a level of 0 or 1 and no color
    a_digital_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.write_valid && out_data.write_kind == KIND_DIGITAL)
        |-> (out_data.level_or_duty <= 8'd1 && out_data.red == 8'd0
             && out_data.green == 8'd0 && out_data.blue == 8'd0))
        else $error("bad digital write");

    // LED writes carry no level
    a_led_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.write_valid && out_data.write_kind == KIND_LED)
        |-> (out_data.level_or_duty == 8'd0))
        else $error("LED write with level");

    // Status is zero unless a frame is reported
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.frame_done) |-> (out_data.frame_status == ST_COMPLETE))
        else $error("status without frame report");
`endif

endmodule

// ===== bench/tb_pin_command_frame_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_pin_command_frame_decoder_unit;

    import pcfd_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_BYTES  = 600;

    // Parser position inside a frame
    typedef enum logic [2:0] {
        WAIT_HEADER,
        DIG_COUNT,
        DIG_ENTRY,
        PWM_COUNT,
        PWM_ENTRY,
        LED_COUNT,
        LED_ENTRY,
        SKIP_BAD
    } frame_phase_t;

    // Predicts pin writes and frame reports, and checks what the block delivers
    class pin_write_scoreboard;
        logic [63:0]  dig_mask;
        logic [63:0]  pwm_mask;
        logic [63:0]  led_mask;
        frame_phase_t phase;
        logic [7:0]   left;
        logic [1:0]   idx;
        logic [7:0]   pin;
        logic [7:0]   red_h;
        logic [7:0]   green_h;
        out_item_t    pending_writes[$];
        int           mismatches;
        int           checked;
        int           kind_seen[3];
        int           status_seen[3];

        function new();
            dig_mask   = '0;
            pwm_mask   = '0;
            led_mask   = '0;
            mismatches = 0;
            checked    = 0;
            kind_seen  = '{0, 0, 0};
            status_seen = '{0, 0, 0};
            clear_parse();
        endfunction

        function void clear_parse();
            phase   = WAIT_HEADER;
            left    = '0;
            idx     = '0;
            pin     = '0;
            red_h   = '0;
            green_h = '0;
        endfunction

        function bit pin_set(logic [63:0] m, logic [7:0] p);
            return (int'(p) < PIN_COUNT_DEF) && m[p[5:0]];
        endfunction

        // Advance the parser by one accepted byte and queue its result, if any
        function void note_input(in_item_t it);
            out_item_t  r;
            logic [7:0] b;
            int         duty;
            r = '0;
            b = it.data_byte;
            if (it.frame_first)
                clear_parse();
            case (phase)
                WAIT_HEADER: phase = (b == HEADER_BYTE) ? DIG_COUNT : SKIP_BAD;
                DIG_COUNT, PWM_COUNT:
                begin
                    left = b;
                    idx  = '0;
                    if (phase == DIG_COUNT)
                        phase = (b != 0) ? DIG_ENTRY : PWM_COUNT;
                    else
                        phase = (b != 0) ? PWM_ENTRY : LED_COUNT;
                end
                DIG_ENTRY, PWM_ENTRY:
                begin
                    if (idx == 2'd0)
                    begin
                        pin = b;
                        idx = 2'd1;
                    end
                    else
                    begin
                        if (phase == DIG_ENTRY && pin_set(dig_mask, pin))
                        begin
                            r.write_valid   = 1'b1;
                            r.write_kind    = KIND_DIGITAL;
                            r.pin_number    = pin[5:0];
                            r.level_or_duty = (b != 0) ? 8'd1 : 8'd0;
                        end
                        else if (phase == PWM_ENTRY && pin_set(pwm_mask, pin))
                        begin
                            duty = int'(b) * int'(DUTY_MAX) / int'(PCT_FULL);
                            if (duty > int'(DUTY_MAX))
                                duty = int'(DUTY_MAX);
                            r.write_valid   = 1'b1;
                            r.write_kind    = KIND_PWM;
                            r.pin_number    = pin[5:0];
                            r.level_or_duty = duty[7:0];
                        end
                        idx  = 2'd0;
                        left = left - 8'd1;
                        if (left == 0)
                            phase = (phase == DIG_ENTRY) ? PWM_COUNT : LED_COUNT;
                    end
                end
                LED_COUNT:
                begin
                    left  = b;
                    idx   = '0;
                    phase = LED_ENTRY;
                end
                LED_ENTRY:
                begin
                    if (left != 0)
                    begin
                        case (idx)
                            2'd0: pin = b;
                            2'd1: red_h = b;
                            2'd2: green_h = b;
                            default:
                            begin
                                if (pin_set(led_mask, pin))
                                begin
                                    r.write_valid = 1'b1;
                                    r.write_kind  = KIND_LED;
                                    r.pin_number  = pin[5:0];
                                    r.red         = red_h;
                                    r.green       = green_h;
                                    r.blue        = b;
                                end
                                left = left - 8'd1;
                            end
                        endcase
                        idx = idx + 2'd1;
                    end
                end
                default: ;
            endcase
            if (it.frame_last)
            begin
                r.frame_done = 1'b1;
                if (phase == SKIP_BAD)
                    r.frame_status = ST_BAD_HEADER;
                else if (phase == LED_ENTRY)
                    r.frame_status = ST_COMPLETE;
                else
                    r.frame_status = ST_EARLY_END;
                clear_parse();
            end
            if (r.write_valid || r.frame_done)
                pending_writes = {pending_writes, r};
        endfunction

        function void compare_field(string name, int exp_v, int got_v);
            if (exp_v != got_v)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH result %0d field %s: expected %0d, got %0d",
                             checked, name, exp_v, got_v);
            end
        endfunction

        // Compare one delivered result with the oldest prediction
        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH unexpected result: got %h", got);
                return;
            end
            exp_r = pending_writes.pop_front();
            compare_field("write_valid", exp_r.write_valid, got.write_valid);
            compare_field("write_kind", exp_r.write_kind, got.write_kind);
            compare_field("pin_number", exp_r.pin_number, got.pin_number);
            compare_field("level_or_duty", exp_r.level_or_duty, got.level_or_duty);
            compare_field("red", exp_r.red, got.red);
            compare_field("green", exp_r.green, got.green);
            compare_field("blue", exp_r.blue, got.blue);
            compare_field("frame_done", exp_r.frame_done, got.frame_done);
            compare_field("frame_status", exp_r.frame_status, got.frame_status);
            if (exp_r.write_valid && exp_r.write_kind <= KIND_LED)
                kind_seen[exp_r.write_kind]++;
            if (exp_r.frame_done && exp_r.frame_status <= ST_BAD_HEADER)
                status_seen[exp_r.frame_status]++;
            checked++;
        endfunction

        function int failures();
            return mismatches + pending_writes.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_item_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_item_t              out_data;

    pin_write_scoreboard    sb;
    bit                     gaps_on = 1'b1;
    bit                     stalls_on = 1'b1;
    bit                     hold_request = 1'b0;
    int                     bytes_sent = 0;
    int                     frames_sent = 0;
    int                     quiet_cycles = 0;

    pin_command_frame_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    always #1 clk = ~clk;

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Stop the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb_pin_command_frame_decoder_unit NOT OK");
            $finish;
        end
    end

    // Drive output ready: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        in_item_t it;
        it.data_byte   = b;
        it.frame_first = first;
        it.frame_last  = last;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it);
        bytes_sent++;
    endtask

    // Send a byte list as one frame, with optional start and end marks
    task automatic send_frame(input logic [7:0] fb[$], input bit mark_first,
                              input bit mark_last);
        for (int i = 0; i < fb.size(); i++)
            send_byte(fb[i], mark_first && i == 0, mark_last && i == fb.size() - 1);
        frames_sent++;
    endtask

    // Drain the block, then write all three pin masks
    task automatic load_pin_masks(input logic [63:0] dig, input logic [63:0] pwm,
                                  input logic [63:0] led);
        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_DIGITAL_MASK;
        cfg_data     <= dig;
        @(posedge clk);
        cfg_index    <= REG_PWM_MASK;
        cfg_data     <= pwm;
        @(posedge clk);
        cfg_index    <= REG_LED_MASK;
        cfg_data     <= led;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sb.dig_mask = dig;
        sb.pwm_mask = pwm;
        sb.led_mask = led;
    endtask

    function automatic logic [7:0] random_pin();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(64, 255));
        return 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] random_value(input int section);
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return (section == 1) ? PCT_FULL : 8'hFF;
            2: return 8'($urandom_range(0, 255));
            default: return (section == 1) ? 8'($urandom_range(0, 100))
                                           : 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build and send one random frame: mostly well formed, some broken
    task automatic send_random_frame();
        logic [7:0] fb[$];
        logic [7:0] hdr;
        int         n;
        int         cut;
        bit         mark_first;
        bit         mark_last;
        hdr = HEADER_BYTE;
        if ($urandom_range(0, 9) == 0)
        begin
            hdr = 8'($urandom_range(0, 255));
            if (hdr == HEADER_BYTE)
                hdr = 8'h00;
        end
        fb = {fb, hdr};
        for (int s = 0; s < 3; s++)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
            fb = {fb, 8'(n)};
            for (int e = 0; e < n && fb.size() < 60; e++)
            begin
                fb = {fb, random_pin()};
                if (s == 2)
                    repeat (3) fb = {fb, 8'($urandom_range(0, 255))};
                else
                    fb = {fb, random_value(s)};
            end
        end
        repeat ($urandom_range(0, 2)) fb = {fb, 8'($urandom_range(0, 255))};
        // cut long frames and some others short, leaving partial entries
        if (fb.size() > 40 || $urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, (fb.size() < 40) ? fb.size() : 40);
            while (fb.size() > cut)
                void'(fb.pop_back());
        end
        mark_first = ($urandom_range(0, 7) != 0);
        mark_last  = ($urandom_range(0, 9) != 0);
        send_frame(fb, mark_first, mark_last);
    endtask

    task automatic run_random_phase(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
            send_random_frame();
    endtask

    initial
    begin
        logic [7:0] fb[$];
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single byte frames with reset masks
        fb = '{HEADER_BYTE};
        send_frame(fb, 1'b1, 1'b1);
        fb = '{8'h55};
        send_frame(fb, 1'b1, 1'b1);

        load_pin_masks('1, '1, '1);
        // Full frame: digital 0 and nonzero, pin 63, PWM 100 and above, pin out of range,
        // one LED entry and a trailing byte
        fb = '{HEADER_BYTE, 8'd2, 8'd0, 8'd0, 8'd63, 8'hFF,
               8'd3, 8'd5, PCT_FULL, 8'd7, 8'hFF, 8'd64, 8'd50,
               8'd1, 8'd63, 8'h00, 8'hFF, 8'h80, 8'h12};
        send_frame(fb, 1'b1, 1'b1);
        // Partial entry at frame end is dropped
        fb = '{HEADER_BYTE, 8'd1, 8'd5};
        send_frame(fb, 1'b1, 1'b1);
        // LED count read but entries missing
        fb = '{HEADER_BYTE, 8'd0, 8'd0, 8'd2, 8'd1};
        send_frame(fb, 1'b1, 1'b1);

        // Long output hold-off while digital writes keep coming
        fb = '{HEADER_BYTE, 8'd40};
        for (int i = 0; i < 40; i++)
        begin
            fb = {fb, 8'(i)};
            fb = {fb, 8'(i + 1)};
        end
        fb = {fb, 8'd0};
        fb = {fb, 8'd0};
        hold_request = 1'b1;
        send_frame(fb, 1'b1, 1'b1);

        // Random frames under several mask settings
        load_pin_masks({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        run_random_phase(RANDOM_BYTES / 6);
        load_pin_masks('0, '1, {$urandom, $urandom});
        run_random_phase(RANDOM_BYTES / 6);
        load_pin_masks(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                       64'h8000_0000_0000_0001);
        run_random_phase(RANDOM_BYTES / 6);
        load_pin_masks({$urandom, $urandom}, '0, '1);
        run_random_phase(RANDOM_BYTES / 6);
        load_pin_masks('1, '1, '1);
        run_random_phase(RANDOM_BYTES / 6);
        // Final stretch at full rate
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_phase(RANDOM_BYTES / 6);

        in_valid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d bytes in %0d frames, %0d results checked.",
                 bytes_sent, frames_sent, sb.checked);
        $display("Writes digital/PWM/LED: %0d/%0d/%0d; status complete/early/bad: %0d/%0d/%0d",
                 sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2],
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
        if (sb.failures() == 0)
            $display("tb_pin_command_frame_decoder_unit OK");
        else
            $display("tb_pin_command_frame_decoder_unit NOT OK");
        $finish;
    end

endmodule
